@@ src/mc_pkg.sv @@
// ----------------------------------------------------------------------------
// mc_pkg
// Shared sizes, codes and memory port bundles of the depth-first maze carver.
// ----------------------------------------------------------------------------
package mc_pkg;

   // grid and stack sizing
   localparam int MAX_WIDTH   = 64;
   localparam int MAX_HEIGHT  = 64;
   localparam int STACK_DEPTH = 4096;

   // coordinate and address widths
   localparam int XW      = $clog2(MAX_WIDTH);
   localparam int YW      = $clog2(MAX_HEIGHT);
   localparam int AW      = $clog2(STACK_DEPTH);
   localparam int CW      = AW + 1;
   localparam int ENTRY_W = XW + YW;

   // configuration register format
   localparam int CFG_W       = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int GRID_RESET  = 16;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

   // width for bound compares: holds both the register range and the grid maximum
   localparam int MAX_DIM  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DIM_BITS = $clog2(MAX_DIM + 1);
   localparam int DIM_W    = ((DIM_BITS > CFG_W) ? DIM_BITS : CFG_W) + 1;

   // response field widths
   localparam int CELL_W = 6;
   localparam int EVT_W  = 2;
   localparam int DIR_W  = 2;

   // event codes
   localparam logic [EVT_W-1:0] EVT_STARTED = 2'd0;
   localparam logic [EVT_W-1:0] EVT_CARVED  = 2'd1;
   localparam logic [EVT_W-1:0] EVT_RETRY   = 2'd2;
   localparam logic [EVT_W-1:0] EVT_BACK    = 2'd3;

   // request kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_STEP  = 1'b1;

   // direction codes
   localparam logic [DIR_W-1:0] DIR_NORTH = 2'd0;
   localparam logic [DIR_W-1:0] DIR_EAST  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_SOUTH = 2'd2;
   localparam logic [DIR_W-1:0] DIR_WEST  = 2'd3;

   // visited map port: one row of the grid per entry
   typedef struct packed {
      logic                 we;
      logic [YW-1:0]        waddr;
      logic [MAX_WIDTH-1:0] wdata;
      logic [YW-1:0]        raddr;
   } vis_port_type;

   // position stack port: {row, column} per entry
   typedef struct packed {
      logic               we;
      logic [AW-1:0]      waddr;
      logic [ENTRY_W-1:0] wdata;
      logic [AW-1:0]      raddr;
   } stk_port_type;

endpackage

@@ src/mc_req_if.sv @@
// ----------------------------------------------------------------------------
// mc_req_if
// Request channel of the maze carver: start or step with a drawn direction.
// ----------------------------------------------------------------------------
interface mc_req_if;

   logic       valid;
   logic       ready;
   logic       kind;
   logic [1:0] random_direction;

   modport source (output valid, kind, random_direction, input ready);
   modport sink   (input valid, kind, random_direction, output ready);

endinterface

@@ src/mc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mc_rsp_if
// Response channel of the maze carver: one response per request.
// ----------------------------------------------------------------------------
interface mc_rsp_if;

   logic       valid;
   logic       ready;
   logic [1:0] event_res;
   logic [5:0] cell_x;
   logic [5:0] cell_y;
   logic [1:0] carve_direction;
   logic       complete;

   modport source (output valid, event_res, cell_x, cell_y, carve_direction, complete,
                   input ready);
   modport sink   (input valid, event_res, cell_x, cell_y, carve_direction, complete,
                   output ready);

endinterface

@@ src/dfs_maze_carver.sv @@
// ----------------------------------------------------------------------------
// dfs_maze_carver
// Randomised depth-first maze carver with visited map and position stack in RAM.
// ----------------------------------------------------------------------------
//   channel  direction  handshake        contents
//   req      in         valid / ready    kind, random_direction
//   rsp      out        valid / ready    event_res, cell_x, cell_y,
//                                        carve_direction, complete
//   csr      in         csr_we           csr_index, csr_data (grid size)
//
// The visited map holds one grid row per word, and for a step request its
// single read port fetches the north, current and south rows in turn.
// A start request sweeps the map: one map row is cleared per cycle. Reset
// leaves the block idle with the maze finished; the map is not cleared by
// reset, only by a start request. A stalled response holds the sequencer in
// its final state; the next request is taken once it is back idle.
// ----------------------------------------------------------------------------
module dfs_maze_carver import mc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   mc_req_if.sink               req,
   mc_rsp_if.source             rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   logic [CFG_W-1:0]     grid_width_ff, grid_width_in;
   logic [CFG_W-1:0]     grid_height_ff, grid_height_in;
   logic [DIM_W-1:0]     eff_width;
   logic [DIM_W-1:0]     eff_height;
   vis_port_type         vis;
   stk_port_type         stk;
   logic [MAX_WIDTH-1:0] vis_rdata;
   logic [ENTRY_W-1:0]   stk_rdata;

   // configuration writes
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      if (csr_we) begin
         case (csr_index)
            REG_GRID_WIDTH:  grid_width_in  = csr_data;
            REG_GRID_HEIGHT: grid_height_in = csr_data;
            default:         grid_width_in  = grid_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= CFG_W'(GRID_RESET);
         grid_height_ff <= CFG_W'(GRID_RESET);
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
      end
   end

   // grid size limited to the map dimensions
   assign eff_width  = (DIM_W'(grid_width_ff) > DIM_W'(MAX_WIDTH)) ?
                       DIM_W'(MAX_WIDTH) : DIM_W'(grid_width_ff);
   assign eff_height = (DIM_W'(grid_height_ff) > DIM_W'(MAX_HEIGHT)) ?
                       DIM_W'(MAX_HEIGHT) : DIM_W'(grid_height_ff);

   // walker sequencer
   mc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .vis        (vis),
      .vis_rdata  (vis_rdata),
      .stk        (stk),
      .stk_rdata  (stk_rdata)
   );

   // visited map, one grid row per word
   mc_ram #(
      .WIDTH (MAX_WIDTH),
      .DEPTH (MAX_HEIGHT)
   ) u_vis_ram (
      .clock (clock),
      .we    (vis.we),
      .waddr (vis.waddr),
      .wdata (vis.wdata),
      .raddr (vis.raddr),
      .rdata (vis_rdata)
   );

   // position stack
   mc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STACK_DEPTH)
   ) u_stk_ram (
      .clock (clock),
      .we    (stk.we),
      .waddr (stk.waddr),
      .wdata (stk.wdata),
      .raddr (stk.raddr),
      .rdata (stk_rdata)
   );

endmodule

@@ src/mc_ram.sv @@
// ----------------------------------------------------------------------------
// mc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/mc_ctrl.sv @@
// ----------------------------------------------------------------------------
// mc_ctrl
// Walker sequencer: reads the three neighbour rows of the visited map, decides
// carve, retry or backtrack, updates map and stack and registers the response.
// ----------------------------------------------------------------------------
module mc_ctrl import mc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   mc_req_if.sink               req,
   mc_rsp_if.source             rsp,
   input  logic [DIM_W-1:0]     eff_width,
   input  logic [DIM_W-1:0]     eff_height,
   output vis_port_type         vis,
   input  logic [MAX_WIDTH-1:0] vis_rdata,
   output stk_port_type         stk,
   input  logic [ENTRY_W-1:0]   stk_rdata
);

   typedef enum logic [5:0] {
      ST_IDLE      = 6'b000001,
      ST_RD_C      = 6'b000010,
      ST_RD_S      = 6'b000100,
      ST_EVAL      = 6'b001000,
      ST_CLEAR     = 6'b010000,
      ST_START_RSP = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic [XW-1:0]        wx_ff, wx_in;
   logic [YW-1:0]        wy_ff, wy_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 fin_ff, fin_in;
   logic [DIR_W-1:0]     dir_ff, dir_in;
   logic [MAX_WIDTH-1:0] row_n_ff, row_n_in;
   logic [MAX_WIDTH-1:0] row_c_ff, row_c_in;
   logic [YW-1:0]        clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [EVT_W-1:0]     evt_ff, evt_in;
   logic [CELL_W-1:0]    cx_ff, cx_in;
   logic [CELL_W-1:0]    cy_ff, cy_in;
   logic [DIR_W-1:0]     cd_ff, cd_in;
   logic                 done_ff, done_in;

   logic                 accept;
   logic                 rsp_free;
   logic [CW-1:0]        cnt_m1;
   logic                 not_full;
   logic [DIM_W-1:0]     wx_ext, wy_ext;
   logic [DIM_W-1:0]     nx   [4];
   logic [DIM_W-1:0]     ny   [4];
   logic [3:0]           seen;
   logic [3:0]           ok;
   logic                 any_ok;
   logic [XW-1:0]        tx;
   logic [YW-1:0]        ty;
   logic [MAX_WIDTH-1:0] new_row;
   logic [YW-1:0]        map_raddr;

   assign accept   = req.valid && req.ready;
   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign cnt_m1   = cnt_ff - 1'b1;
   assign not_full = cnt_ff != CW'(STACK_DEPTH);
   assign wx_ext   = DIM_W'(wx_ff);
   assign wy_ext   = DIM_W'(wy_ff);

   // neighbour coordinates, visited bits and move legality per direction
   always_comb begin
      for (int d = 0; d < 4; d++) begin
         nx[d] = wx_ext;
         ny[d] = wy_ext;
         case (DIR_W'(d))
            DIR_NORTH: ny[d] = wy_ext - 1'b1;
            DIR_EAST:  nx[d] = wx_ext + 1'b1;
            DIR_SOUTH: ny[d] = wy_ext + 1'b1;
            DIR_WEST:  nx[d] = wx_ext - 1'b1;
            default:   nx[d] = wx_ext;
         endcase
      end
      seen[DIR_NORTH] = row_n_ff[XW'(nx[DIR_NORTH])];
      seen[DIR_EAST]  = row_c_ff[XW'(nx[DIR_EAST])];
      seen[DIR_SOUTH] = vis_rdata[XW'(nx[DIR_SOUTH])];
      seen[DIR_WEST]  = row_c_ff[XW'(nx[DIR_WEST])];
      for (int d = 0; d < 4; d++) begin
         ok[d] = not_full && (nx[d] != '0) && (ny[d] != '0)
               && ((nx[d] + 1'b1) < eff_width) && ((ny[d] + 1'b1) < eff_height)
               && !seen[d];
      end
      any_ok = |ok;
   end

   // target cell of the drawn direction and its updated map row
   always_comb begin
      tx = XW'(nx[dir_ff]);
      ty = YW'(ny[dir_ff]);
      case (dir_ff)
         DIR_NORTH: new_row = row_n_ff;
         DIR_SOUTH: new_row = vis_rdata;
         default:   new_row = row_c_ff;
      endcase
      new_row = new_row | (MAX_WIDTH'(1) << tx);
   end

   // map read row follows the sequencer: north, current, then south
   always_comb begin
      map_raddr = wy_ff;
      case (state_ff)
         ST_IDLE:          map_raddr = wy_ff - 1'b1;
         ST_RD_C:          map_raddr = wy_ff;
         ST_RD_S, ST_EVAL: map_raddr = wy_ff + 1'b1;
         default:          map_raddr = wy_ff;
      endcase
   end

   // sequencer, map and stack writes, response register
   always_comb begin
      state_in     = state_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      cnt_in       = cnt_ff;
      fin_in       = fin_ff;
      dir_in       = dir_ff;
      row_n_in     = row_n_ff;
      row_c_in     = row_c_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      evt_in       = evt_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cd_in        = cd_ff;
      done_in      = done_ff;
      vis.raddr    = map_raddr;
      vis.we       = 1'b0;
      vis.waddr    = ty;
      vis.wdata    = new_row;
      // stack top is read throughout the request
      stk.raddr    = cnt_m1[AW-1:0];
      stk.waddr    = cnt_ff[AW-1:0];
      stk.wdata    = {wy_ff, wx_ff};
      stk.we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dir_in = req.random_direction;
               clr_in = '0;
               state_in = (req.kind == KIND_START) ? ST_CLEAR : ST_RD_C;
            end
         end
         ST_RD_C: begin
            row_n_in = vis_rdata;
            state_in = ST_RD_S;
         end
         ST_RD_S: begin
            row_c_in = vis_rdata;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               cx_in        = CELL_W'(wx_ff);
               cy_in        = CELL_W'(wy_ff);
               cd_in        = DIR_NORTH;
               evt_in       = EVT_BACK;
               done_in      = 1'b0;
               state_in     = ST_IDLE;
               if (fin_ff) begin
                  done_in = 1'b1;
               end else if (!any_ok) begin
                  // popped cells were marked when first entered, so no map write
                  if (cnt_ff == '0) begin
                     fin_in  = 1'b1;
                     done_in = 1'b1;
                  end else begin
                     cnt_in = cnt_m1;
                     wx_in  = stk_rdata[XW-1:0];
                     wy_in  = stk_rdata[ENTRY_W-1:XW];
                     if (cnt_m1 == '0) begin
                        fin_in  = 1'b1;
                        done_in = 1'b1;
                     end
                  end
               end else if (!ok[dir_ff]) begin
                  evt_in = EVT_RETRY;
               end else begin
                  evt_in = EVT_CARVED;
                  cd_in  = dir_ff;
                  stk.we = 1'b1;
                  vis.we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
                  wx_in  = tx;
                  wy_in  = ty;
               end
            end
         end
         ST_CLEAR: begin
            // sweep every row, leaving only the start cell marked
            vis.we    = 1'b1;
            vis.waddr = clr_ff;
            vis.wdata = (clr_ff == YW'(1)) ? (MAX_WIDTH'(1) << 1) : '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == YW'(MAX_HEIGHT - 1)) begin
               state_in = ST_START_RSP;
            end
         end
         ST_START_RSP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               evt_in       = EVT_STARTED;
               cx_in        = CELL_W'(1);
               cy_in        = CELL_W'(1);
               cd_in        = DIR_NORTH;
               done_in      = 1'b0;
               wx_in        = XW'(1);
               wy_in        = YW'(1);
               cnt_in       = '0;
               fin_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wx_ff        <= XW'(1);
         wy_ff        <= YW'(1);
         cnt_ff       <= '0;
         fin_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wx_ff        <= wx_in;
         wy_ff        <= wy_in;
         cnt_ff       <= cnt_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      dir_ff   <= dir_in;
      row_n_ff <= row_n_in;
      row_c_ff <= row_c_in;
      clr_ff   <= clr_in;
      evt_ff   <= evt_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cd_ff    <= cd_in;
      done_ff  <= done_in;
   end

   assign req.ready           = (state_ff == ST_IDLE);
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.event_res       = evt_ff;
   assign rsp.cell_x          = cx_ff;
   assign rsp.cell_y          = cy_ff;
   assign rsp.carve_direction = cd_ff;
   assign rsp.complete        = done_ff;

endmodule

@@ bench/dfs_maze_carver_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfs_maze_carver_tb
// Drives start and step requests into the maze carver under random gaps and
// response stalls. A tracker object mirrors the visited map, the position
// stack and the walker. It predicts the response to every accepted request and
// checks each response field by field. Grid sizes move through the extremes,
// including values past the maximum and values too small to leave an interior.
// ----------------------------------------------------------------------------
module dfs_maze_carver_tb import mc_pkg::*; ;

   localparam int STALL_LIMIT = 2000;
   localparam int LIVE_TARGET = 850;

   typedef struct packed {
      logic [EVT_W-1:0]  event_res;
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic [DIR_W-1:0]  carve_direction;
      logic              complete;
   } carve_result_type;

   // mirror of the walker, its visited map and stack, plus pending responses
   class carve_tracker;
      bit               visited [MAX_HEIGHT][MAX_WIDTH];
      bit [XW-1:0]      trail_x [STACK_DEPTH];
      bit [YW-1:0]      trail_y [STACK_DEPTH];
      int               depth;
      int               walker_x;
      int               walker_y;
      bit               finished;
      bit [CFG_W-1:0]   grid_width;
      bit [CFG_W-1:0]   grid_height;
      carve_result_type expected_results [$];

      function new();
         depth       = 0;
         walker_x    = 1;
         walker_y    = 1;
         finished    = 1'b1;
         grid_width  = CFG_W'(GRID_RESET);
         grid_height = CFG_W'(GRID_RESET);
         foreach (visited[y, x]) visited[y][x] = 1'b0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [CFG_W-1:0] value);
         if (index == REG_GRID_WIDTH) grid_width = value;
         else grid_height = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // one bit per direction whose neighbour is an unvisited interior cell
      function bit [3:0] free_dirs();
         int w, h, nx, ny, d;
         bit [3:0] mask;
         w = (grid_width > MAX_WIDTH) ? MAX_WIDTH : int'(grid_width);
         h = (grid_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_height);
         mask = '0;
         for (d = 0; d < 4; d++) begin
            nx = walker_x;
            ny = walker_y;
            case (d)
               DIR_NORTH: ny = ny - 1;
               DIR_EAST:  nx = nx + 1;
               DIR_SOUTH: ny = ny + 1;
               default:   nx = nx - 1;
            endcase
            if (depth < STACK_DEPTH && nx >= 1 && ny >= 1 && nx < w - 1 && ny < h - 1)
               mask[d] = !visited[ny][nx];
         end
         return mask;
      endfunction

      // advance the mirror by one accepted request and queue its response
      function void note_request(logic kind, logic [DIR_W-1:0] dir);
         carve_result_type res;
         bit [3:0] free;
         res.event_res       = EVT_BACK;
         res.cell_x          = walker_x[CELL_W-1:0];
         res.cell_y          = walker_y[CELL_W-1:0];
         res.carve_direction = '0;
         res.complete        = 1'b0;
         if (kind == KIND_START) begin
            foreach (visited[y, x]) visited[y][x] = 1'b0;
            depth    = 0;
            walker_x = 1;
            walker_y = 1;
            finished = 1'b0;
            visited[1][1] = 1'b1;
            res.event_res = EVT_STARTED;
            res.cell_x    = CELL_W'(1);
            res.cell_y    = CELL_W'(1);
         end else if (finished) begin
            res.complete = 1'b1;
         end else begin
            free = free_dirs();
            if (free == 0) begin
               // dead end: pop, or give up at once when nothing was ever pushed
               if (depth > 0) begin
                  depth    = depth - 1;
                  walker_x = trail_x[depth];
                  walker_y = trail_y[depth];
                  visited[walker_y][walker_x] = 1'b1;
               end
               if (depth == 0) begin
                  finished     = 1'b1;
                  res.complete = 1'b1;
               end
            end else if (!free[dir]) begin
               res.event_res = EVT_RETRY;
            end else begin
               trail_x[depth] = walker_x[XW-1:0];
               trail_y[depth] = walker_y[YW-1:0];
               depth = depth + 1;
               case (dir)
                  DIR_NORTH: walker_y = walker_y - 1;
                  DIR_EAST:  walker_x = walker_x + 1;
                  DIR_SOUTH: walker_y = walker_y + 1;
                  default:   walker_x = walker_x - 1;
               endcase
               visited[walker_y][walker_x] = 1'b1;
               res.event_res       = EVT_CARVED;
               res.carve_direction = dir;
            end
         end
         expected_results.push_back(res);
      endfunction

      // compare a response with the oldest prediction, naming every bad field
      function bit check_response(carve_result_type got, output string why);
         carve_result_type want;
         why = "";
         if (expected_results.size() == 0) begin
            why = $sformatf("response with nothing pending: event %0d at (%0d,%0d)",
                            got.event_res, got.cell_x, got.cell_y);
            return 1'b0;
         end
         want = expected_results.pop_front();
         if (got.event_res !== want.event_res)
            why = {why, $sformatf(" event %0d/%0d", got.event_res, want.event_res)};
         if (got.cell_x !== want.cell_x)
            why = {why, $sformatf(" cell_x %0d/%0d", got.cell_x, want.cell_x)};
         if (got.cell_y !== want.cell_y)
            why = {why, $sformatf(" cell_y %0d/%0d", got.cell_y, want.cell_y)};
         if (got.carve_direction !== want.carve_direction)
            why = {why, $sformatf(" carve_direction %0d/%0d",
                                  got.carve_direction, want.carve_direction)};
         if (got.complete !== want.complete)
            why = {why, $sformatf(" complete %0d/%0d", got.complete, want.complete)};
         if (why != "")
            why = {"response mismatch (got/want):", why};
         return why == "";
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   mc_req_if req_chan ();
   mc_rsp_if rsp_chan ();

   carve_tracker tracker;
   int           mismatches;
   int           idle_cycles;
   int           live_items;
   bit           no_gaps;

   dfs_maze_carver uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   task automatic report_mismatch(input string why);
      mismatches++;
      $display("%0t: %s", $time, why);
   endtask

   // mostly short gaps, a few long ones, none at all in burst phases
   function automatic int draw_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   // present one request and wait for it to be taken
   task automatic send_request(input logic kind, input logic [DIR_W-1:0] dir);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid            = 1'b1;
      req_chan.kind             = kind;
      req_chan.random_direction = dir;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (kind == KIND_START || !tracker.finished) live_items++;
      tracker.note_request(kind, dir);
      @(negedge clock);
   endtask

   // resize the grid once every pending response is back and the block is idle
   task automatic write_grid(input int w, input int h);
      req_chan.valid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
      csr_we    = 1'b1;
      csr_index = REG_GRID_WIDTH;
      csr_data  = w[CFG_W-1:0];
      @(posedge clock);
      tracker.write_reg(csr_index, csr_data);
      @(negedge clock);
      csr_index = REG_GRID_HEIGHT;
      csr_data  = h[CFG_W-1:0];
      @(posedge clock);
      tracker.write_reg(csr_index, csr_data);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // one maze: mostly good moves with some random draws, odd restarts and idle steps
   task automatic carve_phase(input int cap);
      int              n;
      bit [3:0]        free;
      logic [DIR_W-1:0] dir;
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) == 0) send_request(KIND_STEP, DIR_W'($urandom_range(0, 3)));
      send_request(KIND_START, DIR_W'($urandom_range(0, 3)));
      n = 0;
      while (!tracker.finished && n < cap) begin
         free = tracker.free_dirs();
         if (free != 0 && $urandom_range(0, 99) < 75) begin
            do dir = DIR_W'($urandom_range(0, 3)); while (!free[dir]);
         end else begin
            dir = DIR_W'($urandom_range(0, 3));
         end
         if ($urandom_range(0, 199) == 0) send_request(KIND_START, dir);
         else send_request(KIND_STEP, dir);
         n++;
      end
      repeat ($urandom_range(0, 2)) send_request(KIND_STEP, DIR_W'($urandom_range(0, 3)));
   endtask

   function automatic int pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(3, 10);
      if (r < 90) return $urandom_range(11, 24);
      return $urandom_range(25, 127);
   endfunction

   // response side: random stalls between accepted responses
   initial begin
      int gap;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
         @(negedge clock);
      end
   end

   // response checker
   always @(posedge clock) begin : check_rsp
      carve_result_type got;
      string            why;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.event_res       = rsp_chan.event_res;
         got.cell_x          = rsp_chan.cell_x;
         got.cell_y          = rsp_chan.cell_y;
         got.carve_direction = rsp_chan.carve_direction;
         got.complete        = rsp_chan.complete;
         if (!tracker.check_response(got, why)) report_mismatch(why);
      end
   end

   // watchdog on cycles with no handshake on either channel
   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("dfs_maze_carver_tb: done, errors");
            $finish;
         end
      end
   end

   // stimulus
   initial begin
      int fixed_w [9];
      int fixed_h [9];
      int w, h, cap;
      fixed_w     = '{64, 127, 0, 1, 2, 64, 3, 127, 65};
      fixed_h     = '{64, 127, 0, 2, 64, 3, 127, 5, 10};
      tracker     = new();
      mismatches  = 0;
      idle_cycles = 0;
      live_items  = 0;
      no_gaps     = 1'b0;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_index   = REG_GRID_WIDTH;
      csr_data    = '0;
      req_chan.valid            = 1'b0;
      req_chan.kind             = KIND_STEP;
      req_chan.random_direction = DIR_NORTH;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // idle step before any start, then walls and visited cells on the default grid
      send_request(KIND_STEP, DIR_WEST);
      send_request(KIND_START, DIR_SOUTH);
      send_request(KIND_STEP, DIR_NORTH);
      send_request(KIND_STEP, DIR_WEST);
      send_request(KIND_STEP, DIR_EAST);
      send_request(KIND_STEP, DIR_SOUTH);
      send_request(KIND_STEP, DIR_WEST);
      send_request(KIND_STEP, DIR_NORTH);
      // restart in the middle of a maze
      send_request(KIND_START, DIR_EAST);
      send_request(KIND_STEP, DIR_SOUTH);

      // smallest grid: no interior move, completes without a pop
      write_grid(3, 3);
      send_request(KIND_START, DIR_NORTH);
      send_request(KIND_STEP, DIR_EAST);
      send_request(KIND_STEP, DIR_SOUTH);

      // two by two interior: carve round, then back out to an empty stack
      write_grid(4, 4);
      send_request(KIND_START, DIR_WEST);
      send_request(KIND_STEP, DIR_EAST);
      send_request(KIND_STEP, DIR_SOUTH);
      send_request(KIND_STEP, DIR_WEST);
      send_request(KIND_STEP, DIR_NORTH);
      send_request(KIND_STEP, DIR_EAST);
      send_request(KIND_STEP, DIR_WEST);
      send_request(KIND_STEP, DIR_SOUTH);

      // grid extremes, clamped sizes and sizes without interior
      foreach (fixed_w[i]) begin
         write_grid(fixed_w[i], fixed_h[i]);
         carve_phase(120);
      end

      // random grids, mostly small so that mazes run to completion
      while (live_items < LIVE_TARGET) begin
         w = pick_dim();
         h = pick_dim();
         write_grid(w, h);
         // keep the total close to the target
         cap = (w > 24 || h > 24) ? 120 : 300;
         if (cap > LIVE_TARGET - live_items) cap = LIVE_TARGET - live_items;
         carve_phase(cap);
      end

      // drain
      req_chan.valid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("dfs_maze_carver_tb: done, clean");
      end else begin
         $display("dfs_maze_carver_tb: done, errors");
      end
      $finish;
   end

endmodule

@@ dfs_maze_carver.f @@
src/mc_pkg.sv
src/mc_req_if.sv
src/mc_rsp_if.sv
src/mc_ram.sv
src/mc_ctrl.sv
src/dfs_maze_carver.sv
bench/dfs_maze_carver_tb.sv
